// ===== src/rmsp_pkg.sv =====
// rmsp_pkg: shared types, constants and datapath step functions for the rmsprop update
`default_nettype none

package rmsp_pkg;

  // field and datapath widths
  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 32;
  localparam int V_W      = 48;
  localparam int G2_W     = 47;
  localparam int T2_W     = 63;
  localparam int NUM_W    = 56;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int SREM_W   = 34;
  localparam int DV_W     = 33;
  localparam int SQRT_STAGES = RAD_W / 2;
  localparam int DIV_STAGES  = NUM_W;

  localparam int NUM_PARAMS_DEF = 4096;

  // register reset values
  localparam logic [15:0] DECAY_GAMMA_RST      = 16'd58982;
  localparam logic [15:0] NEW_WEIGHT_GAMMA_RST = 16'd6554;
  localparam logic [31:0] EPSILON_RST          = 32'd43;
  localparam logic [23:0] LEARNING_RATE_RST    = 24'd16777;

  // register indexes
  typedef enum logic [1:0] {
    REG_DECAY_GAMMA      = 2'd0,
    REG_NEW_WEIGHT_GAMMA = 2'd1,
    REG_EPSILON          = 2'd2,
    REG_LEARNING_RATE    = 2'd3
  } cfg_reg_t;

  // input word
  typedef struct packed {
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] weight;
  } item_t;

  // output word
  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] new_weight;
    logic                     saturated;
  } result_t;

  // configuration group
  typedef struct packed {
    logic [15:0] decay_gamma;
    logic [15:0] new_weight_gamma;
    logic [31:0] stability_epsilon;
    logic [23:0] learning_rate;
  } cfg_t;

  // data riding along through the square root
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              neg;
    logic [DATA_W-1:0] weight;
    logic [NUM_W-1:0]  num;
  } side_t;

  // data riding along through the divider
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              neg;
    logic [DATA_W-1:0] weight;
  } tail_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

  typedef struct packed {
    logic [DV_W-1:0] rem;
    logic            qbit;
  } div_res_t;

  // one digit of the restoring square root
  function automatic sqrt_res_t sqrt_step(input logic [SREM_W-1:0] rem,
                                          input logic [ROOT_W-1:0] root,
                                          input logic [1:0] pair);
    logic [SREM_W+1:0] cat;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    sqrt_res_t         res;
    cat   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = cat - trial;
    if (cat >= trial) begin
      res.rem  = diff[SREM_W-1:0];
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cat[SREM_W-1:0];
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // one quotient bit of the restoring divider
  function automatic div_res_t div_step(input logic [DV_W-1:0] rem,
                                        input logic nbit,
                                        input logic [DV_W-1:0] dv);
    logic [DV_W:0] cat;
    logic [DV_W:0] diff;
    div_res_t      res;
    cat  = {rem, nbit};
    diff = cat - {1'b0, dv};
    if (cat >= {1'b0, dv}) begin
      res.rem  = diff[DV_W-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = cat[DV_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/rmsp_moment.sv =====
// rmsp_moment: slot mapping, second-moment store with clearing pass and the moment update
`default_nettype none

module rmsp_moment #(
  parameter int NUM_PARAMS = rmsp_pkg::NUM_PARAMS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire rmsp_pkg::item_t               in_item,
  input  wire rmsp_pkg::cfg_t                cfg,
  output logic                               clearing,
  output logic                               out_valid,
  output logic [rmsp_pkg::RAD_W-1:0]         out_rad,
  output rmsp_pkg::side_t                    out_side
);

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam logic [24:0] RECIP = 25'((1 << 24) / NUM_PARAMS);
  localparam logic [32:0] NP = 33'(NUM_PARAMS);
  localparam logic [AW-1:0] LAST = AW'(NUM_PARAMS - 1);

  logic [rmsp_pkg::V_W-1:0] mem [0:NUM_PARAMS-1];

  // clearing pass after reset
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // stage 1: magnitude, square and slot quotient estimate
  logic [31:0] g_u;
  logic [31:0] mag_in;
  logic [63:0] sq_in;
  logic [36:0] qprod;

  assign g_u    = in_item.gradient;
  assign mag_in = g_u[31] ? (~g_u + 32'd1) : g_u;
  assign sq_in  = 64'(mag_in) * 64'(mag_in);
  assign qprod  = 37'(in_item.param_index) * 37'(RECIP);

  logic                           v1;
  logic [rmsp_pkg::IDX_W-1:0]     idx1;
  logic                           neg1;
  logic [31:0]                    w1;
  logic [31:0]                    mag1;
  logic [rmsp_pkg::IDX_W-1:0]     q1;
  logic [rmsp_pkg::G2_W-1:0]      g2_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      idx1 <= in_item.param_index;
      neg1 <= g_u[31];
      w1   <= in_item.weight;
      mag1 <= mag_in;
      q1   <= qprod[35:24];
      g2_1 <= sq_in[62:16];
    end
  end

  // stage 2: slot remainder, weighted square and step numerator
  logic [32:0] qn;
  logic [32:0] rem_raw;
  logic [32:0] rem_fix;
  logic [rmsp_pkg::T2_W-1:0]  t2_in;
  logic [rmsp_pkg::NUM_W-1:0] num_in;

  assign qn      = 33'(q1) * NP;
  assign rem_raw = 33'(idx1) - qn;
  assign rem_fix = (rem_raw >= NP) ? (rem_raw - NP) : rem_raw;
  assign t2_in   = 63'(cfg.new_weight_gamma) * 63'(g2_1);
  assign num_in  = 56'(mag1) * 56'(cfg.learning_rate);

  logic                      v2;
  logic [AW-1:0]             slot2;
  logic [rmsp_pkg::T2_W-1:0] t2_2;
  rmsp_pkg::side_t           side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      slot2        <= rem_fix[AW-1:0];
      t2_2         <= t2_in;
      side2.idx    <= idx1;
      side2.neg    <= neg1;
      side2.weight <= w1;
      side2.num    <= num_in;
    end
  end

  // stage 3: store read lands here, read-modify-write with forwarding
  logic                      v3;
  logic [AW-1:0]             slot3;
  logic [rmsp_pkg::T2_W-1:0] t2_3;
  rmsp_pkg::side_t           side3;
  logic [rmsp_pkg::V_W-1:0]  rd;

  logic                      fw_valid;
  logic [AW-1:0]             fw_slot;
  logic [rmsp_pkg::V_W-1:0]  fw_v;

  logic [rmsp_pkg::V_W-1:0]  v_old;
  logic [63:0]               t1;
  logic [64:0]               vsum;
  logic [48:0]               vshift;
  logic [rmsp_pkg::V_W-1:0]  v_new;

  assign v_old  = (fw_valid && (fw_slot == slot3)) ? fw_v : rd;
  assign t1     = 64'(cfg.decay_gamma) * 64'(v_old);
  assign vsum   = 65'(t1) + 65'(t2_3);
  assign vshift = vsum[64:16];
  assign v_new  = vshift[48] ? {rmsp_pkg::V_W{1'b1}} : vshift[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      slot3 <= slot2;
      t2_3  <= t2_2;
      side3 <= side2;
      rd    <= mem[slot2];
    end
  end

  // store write port, shared with the clearing pass
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (adv && v3) begin
      mem[slot3] <= v_new;
    end
  end

  // last written entry, covers the read that raced the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (adv && v3) begin
      fw_valid <= 1'b1;
    end
    if (adv && v3) begin
      fw_slot <= slot3;
      fw_v    <= v_new;
    end
  end

  // stage 4: register the new moment
  logic                     v4;
  logic [rmsp_pkg::V_W-1:0] vv4;
  rmsp_pkg::side_t          side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      vv4   <= v_new;
      side4 <= side3;
    end
  end

  // stage 5: add epsilon and scale into the root radicand
  logic [48:0] s_sum;

  assign s_sum = 49'(vv4) + 49'(cfg.stability_epsilon);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v4;
    end
    if (adv) begin
      out_rad  <= {1'b0, s_sum, 14'b0};
      out_side <= side4;
    end
  end

endmodule

`default_nettype wire

// ===== src/rmsp_sqrt.sv =====
// rmsp_sqrt: pipelined restoring square root, one root bit per stage
`default_nettype none

module rmsp_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [rmsp_pkg::RAD_W-1:0]  in_rad,
  input  wire rmsp_pkg::side_t             in_side,
  output logic                             out_valid,
  output logic [rmsp_pkg::ROOT_W-1:0]      out_root,
  output rmsp_pkg::side_t                  out_side
);

  localparam int N = rmsp_pkg::SQRT_STAGES;

  logic                        vld  [0:N];
  logic [rmsp_pkg::RAD_W-1:0]  rad  [0:N];
  logic [rmsp_pkg::SREM_W-1:0] rem  [0:N];
  logic [rmsp_pkg::ROOT_W-1:0] root [0:N];
  rmsp_pkg::side_t             side [0:N];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  // one stage per pair of radicand bits
  for (genvar k = 0; k < N; k++) begin : g_stage
    rmsp_pkg::sqrt_res_t res;

    assign res = rmsp_pkg::sqrt_step(rem[k], root[k],
                                     rad[k][rmsp_pkg::RAD_W-1:rmsp_pkg::RAD_W-2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        rad[k+1]  <= {rad[k][rmsp_pkg::RAD_W-3:0], 2'b00};
        rem[k+1]  <= res.rem;
        root[k+1] <= res.root;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_side  = side[N];

endmodule

`default_nettype wire

// ===== src/rmsp_div.sv =====
// rmsp_div: pipelined restoring divider for the step size, one quotient bit per stage
`default_nettype none

module rmsp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [rmsp_pkg::ROOT_W-1:0] in_root,
  input  wire rmsp_pkg::side_t             in_side,
  output logic                             out_valid,
  output logic [rmsp_pkg::NUM_W-1:0]       out_quot,
  output rmsp_pkg::tail_t                  out_tail
);

  localparam int N = rmsp_pkg::DIV_STAGES;

  logic                       vld  [0:N];
  logic [rmsp_pkg::NUM_W-1:0] num  [0:N];
  logic [rmsp_pkg::NUM_W-1:0] quot [0:N];
  logic [rmsp_pkg::DV_W-1:0]  rem  [0:N];
  logic [rmsp_pkg::DV_W-1:0]  dv   [0:N];
  rmsp_pkg::tail_t            tail [0:N];

  // divisor is twice the root, a zero root counts as one
  logic [rmsp_pkg::ROOT_W-1:0] root_nz;

  assign root_nz = (in_root == '0) ? rmsp_pkg::ROOT_W'(1) : in_root;

  assign vld[0]         = in_valid;
  assign num[0]         = in_side.num;
  assign quot[0]        = '0;
  assign rem[0]         = '0;
  assign dv[0]          = {root_nz, 1'b0};
  assign tail[0].idx    = in_side.idx;
  assign tail[0].neg    = in_side.neg;
  assign tail[0].weight = in_side.weight;

  // one stage per quotient bit, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    rmsp_pkg::div_res_t res;

    assign res = rmsp_pkg::div_step(rem[k], num[k][rmsp_pkg::NUM_W-1], dv[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        num[k+1]  <= {num[k][rmsp_pkg::NUM_W-2:0], 1'b0};
        quot[k+1] <= {quot[k][rmsp_pkg::NUM_W-2:0], res.qbit};
        rem[k+1]  <= res.rem;
        dv[k+1]   <= dv[k];
        tail[k+1] <= tail[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_quot  = quot[N];
  assign out_tail  = tail[N];

endmodule

`default_nettype wire

// ===== src/rmsprop_parameter_update.sv =====
// rmsprop_parameter_update: top level, config registers, pipeline glue and result register
// Pipeline: 5 moment stages, 32 square-root stages, 56 divider stages and
// 1 output register between an accepted word and its result word.
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Reset: rst clears control and loads register defaults, then the moment store is
// cleared one entry per cycle, every entry once, with item_stall held high.
`default_nettype none

module rmsprop_parameter_update #(
  parameter int NUM_PARAMS = rmsp_pkg::NUM_PARAMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire rmsp_pkg::item_t            item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output rmsp_pkg::result_t               result,
  input  wire logic                       cfg_write,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [rmsp_pkg::CFG_W-1:0] cfg_data
);

  rmsp_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_gamma       <= rmsp_pkg::DECAY_GAMMA_RST;
      cfg.new_weight_gamma  <= rmsp_pkg::NEW_WEIGHT_GAMMA_RST;
      cfg.stability_epsilon <= rmsp_pkg::EPSILON_RST;
      cfg.learning_rate     <= rmsp_pkg::LEARNING_RATE_RST;
    end else if (cfg_write) begin
      unique case (rmsp_pkg::cfg_reg_t'(cfg_index))
        rmsp_pkg::REG_DECAY_GAMMA:      cfg.decay_gamma       <= cfg_data[15:0];
        rmsp_pkg::REG_NEW_WEIGHT_GAMMA: cfg.new_weight_gamma  <= cfg_data[15:0];
        rmsp_pkg::REG_EPSILON:          cfg.stability_epsilon <= cfg_data[31:0];
        rmsp_pkg::REG_LEARNING_RATE:    cfg.learning_rate     <= cfg_data[23:0];
      endcase
    end
  end

  // pipeline advance, held only by a stalled result word
  logic adv;
  logic clearing;
  logic accept;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = clearing || !adv;
  assign accept     = item_valid && !item_stall;

  logic                          m_valid;
  logic [rmsp_pkg::RAD_W-1:0]    m_rad;
  rmsp_pkg::side_t               m_side;

  rmsp_moment #(
    .NUM_PARAMS(NUM_PARAMS)
  ) u_moment (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (accept),
    .in_item  (item),
    .cfg      (cfg),
    .clearing (clearing),
    .out_valid(m_valid),
    .out_rad  (m_rad),
    .out_side (m_side)
  );

  logic                          s_valid;
  logic [rmsp_pkg::ROOT_W-1:0]   s_root;
  rmsp_pkg::side_t               s_side;

  rmsp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (m_valid),
    .in_rad   (m_rad),
    .in_side  (m_side),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  logic                          d_valid;
  logic [rmsp_pkg::NUM_W-1:0]    d_quot;
  rmsp_pkg::tail_t               d_tail;

  rmsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_valid),
    .in_root  (s_root),
    .in_side  (s_side),
    .out_valid(d_valid),
    .out_quot (d_quot),
    .out_tail (d_tail)
  );

  // apply the step and saturate to Q8.24
  localparam logic signed [58:0] WMAX = 59'sd2147483647;
  localparam logic signed [58:0] WMIN = -59'sd2147483648;

  logic signed [58:0] w_ext;
  logic signed [58:0] step_ext;
  logic signed [58:0] nw;
  logic               sat_hi;
  logic               sat_lo;
  rmsp_pkg::result_t  result_next;

  assign w_ext    = 59'(signed'(d_tail.weight));
  assign step_ext = signed'({3'b000, d_quot});
  assign nw       = d_tail.neg ? (w_ext + step_ext) : (w_ext - step_ext);
  assign sat_hi   = nw > WMAX;
  assign sat_lo   = nw < WMIN;

  always_comb begin
    result_next.result_index = d_tail.idx;
    result_next.saturated    = sat_hi || sat_lo;
    priority if (sat_hi) begin
      result_next.new_weight = WMAX[31:0];
    end else if (sat_lo) begin
      result_next.new_weight = WMIN[31:0];
    end else begin
      result_next.new_weight = nw[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= d_valid;
    end
    if (adv) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  // no word is taken while the store is being cleared
  a_clear_blocks: assert property (@(posedge clk) clearing |-> item_stall)
    else $error("word accepted during clearing pass");

  // reset always starts a clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> (clearing && item_stall))
    else $error("no clearing pass after reset");

  // a saturated result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.new_weight == 32'sh7fffffff || result.new_weight == 32'sh80000000))
    else $error("saturated flag without a limit value");
`endif

endmodule

`default_nettype wire
